>>> design/mau_pkg.sv
// ---------------------------------------------------------------------------
// mau_pkg: shared types and constants of the modular arithmetic unit
// Mode codes, widths and the controller/datapath command and status structs.
// ---------------------------------------------------------------------------
`default_nettype none
package mau_pkg;
  localparam int unsigned ModW = 31;
  localparam int unsigned OpbW = 64;
  localparam int unsigned DefValueWidth = 32;
  localparam logic [ModW-1:0] ModReset = 31'd13;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0, MODE_SUB = 3'd1, MODE_MUL = 3'd2, MODE_DIV = 3'd3,
    MODE_INV = 3'd4, MODE_POW = 3'd5, MODE_NEG = 3'd6, MODE_NONE = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    OP_IDLE    = 4'd0,
    OP_LOAD    = 4'd1,  // capture operands
    OP_REDA    = 4'd2,  // start reduction of a
    OP_REDB    = 4'd3,  // start reduction of b
    OP_SIMPLE  = 4'd4,  // add/sub/neg into result
    OP_MULAB   = 4'd5,  // start a*b mod m
    OP_INVX    = 4'd6,  // Euclid init on x (b for divide, a otherwise)
    OP_EUCSTEP = 4'd7,  // start a division r0/r1
    OP_EUCUPD  = 4'd8,  // update Euclid from quotient
    OP_INVFIN  = 4'd9,  // finish inverse
    OP_POWINIT = 4'd10, // acc=1; base=a unless the exponent is negative
    OP_POWMUL  = 4'd11, // start acc*base
    OP_POWSQ   = 4'd12, // start base*base, shift exp
    OP_MULDIV  = 4'd13, // start a*inv
    OP_ZERO    = 4'd14, // result 0
    OP_POWFIN  = 4'd15  // running product into result
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_go;  // holds off the divider write-back to a/b
    logic pow_acc; // multiply result goes to acc (else base)
    logic inv_to_res;
    logic mul_to_res;
  } mau_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic r1_zero;
    logic inv_ok;
    logic exp_zero;
    logic exp_lsb;
    logic negb;
    logic m_small;
  } mau_sts_t;
endpackage
`default_nettype wire

>>> design/mau_divider.sv
// ---------------------------------------------------------------------------
// mau_divider: radix-2 restoring divider
// Divides a 64-bit dividend by a 64-bit divisor, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module mau_divider import mau_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go,
  input  wire logic [OpbW-1:0] dividend,
  input  wire logic [OpbW-1:0] divisor,
  output logic                 busy,
  output logic [OpbW-1:0]      quot,
  output logic [OpbW-1:0]      rem
);
  logic [OpbW-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [OpbW:0] sh, diff;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    sh = {r_r, q_r[OpbW-1]};
    diff = sh - {1'b0, d_r};
    if (go) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor; cnt_nxt = 7'(OpbW);
    end else if (cnt_r != 7'd0) begin
      // shift one dividend bit in, subtract when it fits
      if (!diff[OpbW]) begin
        r_nxt = diff[OpbW-1:0]; q_nxt = {q_r[OpbW-2:0], 1'b1};
      end else begin
        r_nxt = sh[OpbW-1:0]; q_nxt = {q_r[OpbW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
  end

  assign busy = (cnt_r != 7'd0);
  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

>>> design/mau_datapath.sv
// ---------------------------------------------------------------------------
// mau_datapath: operand, Euclid and power registers of the unit
// Executes one command a cycle; all reductions go through one divider.
// ---------------------------------------------------------------------------
`default_nettype none
module mau_datapath import mau_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mau_cmd_t        cmd,
  input  wire logic [2:0]      mode,
  input  wire logic [31:0]     opa,
  input  wire logic [OpbW-1:0] opb,
  input  wire logic [ModW-1:0] modulus,
  output mau_sts_t             sts,
  output logic [ModW-1:0]      result,
  output logic                 no_inv
);
  localparam int unsigned WA = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  logic [OpbW-1:0] am_r, am_nxt, bm_r, bm_nxt, e_r, e_nxt;
  logic            na_r, na_nxt, nb_r, nb_nxt;
  logic [ModW-1:0] a_r, a_nxt, b_r, b_nxt, m_r, m_nxt, res_r, res_nxt;
  logic [ModW-1:0] acc_r, acc_nxt, base_r, base_nxt;
  logic [ModW:0]   r0_r, r0_nxt, r1_r, r1_nxt; // r0 may equal m
  logic signed [ModW+1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  logic            ni_r, ni_nxt;
  logic [2:0]      md_r, md_nxt;
  logic [1:0]      dsel_r, dsel_nxt; // 0 a,1 b,2 product,3 euclid

  logic            dgo;
  logic [OpbW-1:0] dvd, dvs, quo, rmd;
  logic            dbusy;
  logic [ModW-1:0] rem_m, red;
  logic [ModW:0]   sum;
  logic [ModW-1:0] x_sel;
  logic signed [ModW+1:0] t_fix;
  logic [WA-1:0]   a_w;
  logic [OpbW-1:0] a_sx;
  logic [31:0]     mul_x, mul_y;
  logic [OpbW-1:0] prod;

  mau_divider u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .dividend(dvd), .divisor(dvs),
    .busy(dbusy), .quot(quo), .rem(rmd)
  );

  assign a_w   = opa[WA-1:0];
  assign a_sx  = {{(OpbW-WA){a_w[WA-1]}}, a_w};
  assign rem_m = rmd[ModW-1:0];
  // wrap negative magnitudes up to a non-negative residue
  assign red = ((dsel_r == 2'd0 ? na_r : nb_r) && rem_m != '0) ? m_r - rem_m : rem_m;
  assign x_sel = (md_r == MODE_DIV) ? b_r : a_r;
  assign t_fix = t0_r[ModW+1] ? t0_r + $signed({2'b00, m_r}) : t0_r;

  // one shared multiplier for every modular product
  always_comb begin
    mul_x = {1'b0, a_r}; mul_y = {1'b0, b_r};
    case (cmd.op)
      OP_MULDIV: mul_y = {1'b0, acc_r};
      OP_POWMUL: begin mul_x = {1'b0, acc_r}; mul_y = {1'b0, base_r}; end
      OP_POWSQ:  begin mul_x = {1'b0, base_r}; mul_y = {1'b0, base_r}; end
      default: ;
    endcase
  end
  assign prod = {32'b0, mul_x} * {32'b0, mul_y};

  always_comb begin
    am_nxt = am_r; bm_nxt = bm_r; na_nxt = na_r; nb_nxt = nb_r;
    a_nxt = a_r; b_nxt = b_r; m_nxt = m_r; res_nxt = res_r; e_nxt = e_r;
    acc_nxt = acc_r; base_nxt = base_r; r0_nxt = r0_r; r1_nxt = r1_r;
    t0_nxt = t0_r; t1_nxt = t1_r; ni_nxt = ni_r; md_nxt = md_r; dsel_nxt = dsel_r;
    dgo = 1'b0; dvd = '0; dvs = {{(OpbW-ModW){1'b0}}, m_r};
    sum = '0;
    if (!dbusy && cmd.div_go == 1'b0) begin
      // divider result returns when it goes idle
      if (dsel_r == 2'd0) a_nxt = red;
      if (dsel_r == 2'd1) b_nxt = red;
    end
    case (cmd.op)
      OP_LOAD: begin
        na_nxt = a_w[WA-1];
        am_nxt = na_nxt ? (OpbW'(0) - a_sx) : a_sx;
        nb_nxt = opb[OpbW-1];
        bm_nxt = nb_nxt ? -opb : opb;
        e_nxt  = bm_nxt;
        m_nxt = modulus; md_nxt = mode; ni_nxt = 1'b0; res_nxt = '0;
      end
      OP_REDA: begin dgo = 1'b1; dvd = am_r; dsel_nxt = 2'd0; end
      OP_REDB: begin dgo = 1'b1; dvd = bm_r; dsel_nxt = 2'd1; end
      OP_SIMPLE: begin
        case (md_r)
          MODE_ADD: sum = {1'b0, a_r} + {1'b0, b_r};
          MODE_SUB: sum = {1'b0, a_r} + {1'b0, m_r} - {1'b0, b_r};
          default:  sum = {1'b0, m_r} - {1'b0, a_r};
        endcase
        res_nxt = (sum >= {1'b0, m_r}) ? ModW'(sum - {1'b0, m_r}) : sum[ModW-1:0];
      end
      OP_MULAB: begin
        dgo = 1'b1; dvd = prod; dsel_nxt = 2'd2;
      end
      OP_MULDIV: begin
        dgo = 1'b1; dvd = prod; dsel_nxt = 2'd2;
      end
      OP_POWMUL: begin
        dgo = 1'b1; dvd = prod; dsel_nxt = 2'd2;
      end
      OP_POWSQ: begin
        dgo = 1'b1; dvd = prod; dsel_nxt = 2'd2;
        e_nxt = e_r >> 1;
      end
      OP_INVX: begin
        r0_nxt = {1'b0, m_r}; r1_nxt = {1'b0, x_sel}; t0_nxt = '0;
        t1_nxt = (ModW+2)'(1);
      end
      OP_EUCSTEP: begin
        dgo = 1'b1; dvd = OpbW'(r0_r); dvs = OpbW'(r1_r); dsel_nxt = 2'd3;
      end
      OP_EUCUPD: begin
        r0_nxt = r1_r; r1_nxt = rmd[ModW:0];
        t0_nxt = t1_r;
        t1_nxt = (ModW+2)'(t0_r - $signed(quo[ModW+1:0]) * t1_r);
      end
      OP_INVFIN: begin
        if (r0_r != (ModW+1)'(1)) begin
          ni_nxt = 1'b1; res_nxt = '0;
        end else begin
          acc_nxt = t_fix[ModW-1:0];
          if (cmd.inv_to_res) res_nxt = t_fix[ModW-1:0];
          base_nxt = t_fix[ModW-1:0];
        end
      end
      OP_POWINIT: begin
        acc_nxt = ModW'(1); if (!nb_r) base_nxt = a_r;
      end
      OP_POWFIN: begin res_nxt = acc_r; end
      OP_ZERO: begin res_nxt = '0; end
      default: ;
    endcase
    // retire a finished product; the square that follows a multiply starts
    // in the same cycle the multiply lands in acc
    if (dsel_r == 2'd2 && !dbusy && (cmd.op == OP_IDLE || cmd.op == OP_POWSQ)) begin
      if (cmd.mul_to_res) res_nxt = rem_m;
      else if (cmd.pow_acc) acc_nxt = rem_m;
      else base_nxt = rem_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dsel_r <= 2'd3;
    else dsel_r <= dsel_nxt;
    am_r <= am_nxt; bm_r <= bm_nxt; na_r <= na_nxt; nb_r <= nb_nxt;
    a_r <= a_nxt; b_r <= b_nxt; m_r <= m_nxt; res_r <= res_nxt; e_r <= e_nxt;
    acc_r <= acc_nxt; base_r <= base_nxt; r0_r <= r0_nxt; r1_r <= r1_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; ni_r <= ni_nxt; md_r <= md_nxt;
  end

  assign sts.div_busy = dbusy;
  assign sts.r1_zero  = (r1_r == '0);
  assign sts.inv_ok   = (r0_r == (ModW+1)'(1));
  assign sts.exp_zero = (e_r == '0);
  assign sts.exp_lsb  = e_r[0];
  assign sts.negb     = nb_r;
  assign sts.m_small  = (m_r < ModW'(2));
  assign result = res_r;
  assign no_inv = ni_r;
endmodule
`default_nettype wire

>>> design/mau_controller.sv
// ---------------------------------------------------------------------------
// mau_controller: sequencer of the modular arithmetic unit
// Steps the datapath through reduction, Euclid and square-and-multiply.
// ---------------------------------------------------------------------------
`default_nettype none
module mau_controller import mau_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [2:0] mode,
  input  wire mau_sts_t   sts,
  input  wire logic       out_take,
  output mau_cmd_t        cmd,
  output logic            idle,
  output logic            done
);
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_LOAD  = 13'b0000000000010,
    S_REDA  = 13'b0000000000100,
    S_REDB  = 13'b0000000001000,
    S_DISP  = 13'b0000000010000,
    S_MULW  = 13'b0000000100000,
    S_EUC   = 13'b0000001000000,
    S_EUCW  = 13'b0000010000000,
    S_INVF  = 13'b0000100000000,
    S_POWC  = 13'b0001000000000,
    S_POWMW = 13'b0010000000000,
    S_POWSW = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t st_r, st_nxt;
  logic [2:0] md_r, md_nxt;
  logic w_r, w_nxt; // divider kicked, wait until busy is registered
  logic last_r, last_nxt; // pending multiply is final

  always_comb begin
    st_nxt = st_r; md_nxt = md_r; w_nxt = 1'b0; last_nxt = last_r;
    cmd = '0; cmd.op = OP_IDLE;
    cmd.mul_to_res = last_r; cmd.pow_acc = 1'b0;
    case (st_r)
      S_IDLE: if (start) begin md_nxt = mode; st_nxt = S_LOAD; cmd.op = OP_LOAD; end
      S_LOAD: begin
        if (sts.m_small || md_r == MODE_NONE) begin
          cmd.op = OP_ZERO; st_nxt = S_DONE;
        end else begin
          cmd.op = OP_REDA; w_nxt = 1'b1; st_nxt = S_REDA;
        end
      end
      S_REDA: if (!w_r && !sts.div_busy) begin
        cmd.op = OP_REDB; w_nxt = 1'b1; st_nxt = S_REDB;
      end
      S_REDB: if (!w_r && !sts.div_busy) st_nxt = S_DISP;
      S_DISP: begin
        case (md_r)
          MODE_ADD, MODE_SUB, MODE_NEG: begin cmd.op = OP_SIMPLE; st_nxt = S_DONE; end
          MODE_MUL: begin
            cmd.op = OP_MULAB; w_nxt = 1'b1; last_nxt = 1'b1; st_nxt = S_MULW;
          end
          MODE_POW: begin
            if (sts.negb) begin cmd.op = OP_INVX; st_nxt = S_EUC; end
            else begin cmd.op = OP_POWINIT; st_nxt = S_POWC; end
          end
          default: begin cmd.op = OP_INVX; st_nxt = S_EUC; end
        endcase
      end
      S_MULW: if (!w_r && !sts.div_busy) begin
        st_nxt = S_DONE; last_nxt = 1'b0;
      end
      S_EUC: begin
        if (sts.r1_zero) begin
          cmd.op = OP_INVFIN; cmd.inv_to_res = 1'b1; st_nxt = S_INVF;
        end else begin
          cmd.op = OP_EUCSTEP; w_nxt = 1'b1; st_nxt = S_EUCW;
        end
      end
      S_EUCW: if (!w_r && !sts.div_busy) begin cmd.op = OP_EUCUPD; st_nxt = S_EUC; end
      S_INVF: begin
        if (!sts.inv_ok || md_r == MODE_INV) st_nxt = S_DONE;
        else if (md_r == MODE_DIV) begin
          cmd.op = OP_MULDIV; w_nxt = 1'b1; last_nxt = 1'b1; st_nxt = S_MULW;
        end else begin
          cmd.op = OP_POWINIT; st_nxt = S_POWC;
        end
      end
      S_POWC: begin
        if (sts.exp_zero) begin
          cmd.op = OP_POWFIN; st_nxt = S_DONE;
        end else if (sts.exp_lsb) begin
          cmd.op = OP_POWMUL; w_nxt = 1'b1; st_nxt = S_POWMW;
        end else begin
          cmd.op = OP_POWSQ; w_nxt = 1'b1; st_nxt = S_POWSW;
        end
      end
      S_POWMW: begin
        cmd.pow_acc = 1'b1;
        if (!w_r && !sts.div_busy) begin
          cmd.op = OP_POWSQ; w_nxt = 1'b1; st_nxt = S_POWSW;
        end
      end
      S_POWSW: if (!w_r && !sts.div_busy) st_nxt = S_POWC;
      S_DONE: if (out_take) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; w_r <= 1'b0; last_r <= 1'b0; md_r <= MODE_ADD;
    end else begin
      st_r <= st_nxt; w_r <= w_nxt; last_r <= last_nxt; md_r <= md_nxt;
    end
  end

  assign idle = (st_r == S_IDLE);
  assign done = (st_r == S_DONE);
endmodule
`default_nettype wire

>>> design/modular_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// modular_arithmetic_unit: modular add/sub/mul/div/inverse/power/negate
// Controller sequences a datapath built around one shared radix-2 divider.
// ---------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid/in_ready, in_mode, in_operand_a, in_operand_b | sink
//  out     | out_valid/out_ready, out_result, out_no_inverse        | source
//  cfg     | cfg_we, cfg_data (modulus)                              | sink
//
// Every reduction, product and Euclid quotient runs through one 64-step
// divider. An inverse takes up to ~45 Euclid steps, a power up to 128
// multiplies. One request is in flight at a time; the result holds in its
// register until taken, and in_ready stays low until then. Reset clears the
// modulus to 13 and returns the sequencer to idle.
`default_nettype none
module modular_arithmetic_unit import mau_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [2:0]      in_mode,
  input  wire logic [31:0]     in_operand_a,
  input  wire logic [OpbW-1:0] in_operand_b,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [ModW-1:0]      out_result,
  output logic                 out_no_inverse,
  input  wire logic            cfg_we,
  input  wire logic [ModW-1:0] cfg_data
);
  logic [ModW-1:0] mod_r, mod_nxt;
  mau_cmd_t cmd;
  mau_sts_t sts;
  logic idle, done;

  // hold the modulus; it is to be written only while idle, which the block does not enforce
  assign mod_nxt = cfg_we ? cfg_data : mod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) mod_r <= ModReset;
    else mod_r <= mod_nxt;
  end

  mau_controller u_ctl (
    .clk(clk), .rst_n(rst_n), .start(in_valid & in_ready), .mode(in_mode),
    .sts(sts), .out_take(out_ready), .cmd(cmd), .idle(idle), .done(done)
  );

  mau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .mode(in_mode), .opa(in_operand_a),
    .opb(in_operand_b), .modulus(mod_r), .sts(sts), .result(out_result),
    .no_inv(out_no_inverse)
  );

  assign in_ready  = idle;
  assign out_valid = done;
endmodule
`default_nettype wire

>>> design/mau_checker.sv
// ---------------------------------------------------------------------------
// mau_checker: port-level checks of the modular arithmetic unit
// Watches the handshakes and the zero result on no-inverse at the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module mau_checker import mau_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [ModW-1:0] out_result,
  input wire logic            out_no_inverse
);
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_inverse) |-> out_result == '0) else $error("no_inverse nonzero");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_result))
    else $error("result dropped");
endmodule

bind modular_arithmetic_unit mau_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_result(out_result),
  .out_no_inverse(out_no_inverse)
);
`default_nettype wire

>>> dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the modular arithmetic unit
// Drives mode/operand requests through a queue-fed driver. Each accepted
// request is predicted at acceptance time against a local copy of the
// modulus. Results are checked in order by a monitor. The bench also sweeps
// the modulus through its extremes, varies idling on both channels and
// applies a long stall on the receive side.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
  import mau_pkg::*;

  localparam longint unsigned CycleLimit = 64'd100_000_000;

  typedef struct {
    mode_t       mode;
    logic [31:0] a;
    logic [63:0] b;
  } mau_req_t;

  typedef struct {
    logic [ModW-1:0] result;
    logic            no_inv;
  } mau_res_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [2:0]      in_mode = '0;
  logic [31:0]     in_operand_a = '0;
  logic [OpbW-1:0] in_operand_b = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [ModW-1:0] out_result;
  logic            out_no_inverse;
  logic            cfg_we = 1'b0;
  logic [ModW-1:0] cfg_data = '0;

  mau_req_t pending_reqs[$];
  mau_res_t expected_results[$];
  logic [ModW-1:0] modulus_q = ModReset;
  logic in_took = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  longint unsigned cycles = 0;

  modular_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_result(out_result),
    .out_no_inverse(out_no_inverse), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Wrap a signed value into [0, m): negatives are folded up.
  function automatic longint unsigned wrap_residue(logic [63:0] v, longint unsigned m);
    longint unsigned mag;
    longint unsigned r;
    mag = v[63] ? (64'd0 - v) : v;
    r = mag % m;
    if (v[63] && r != 0) r = m - r;
    return r;
  endfunction

  // Extended Euclid; ok clears when x shares a factor with m.
  function automatic longint unsigned mod_inverse(longint unsigned x, longint unsigned m,
                                                  output bit ok);
    longint r0, r1, r2, t0, t1, t2, q;
    r0 = m; r1 = x; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1; t2 = t0 - q * t1;
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    ok = (r0 == 1);
    if (t0 < 0) t0 += m;
    return longint'(t0) % m;
  endfunction

  function automatic longint unsigned mod_power(longint unsigned base, logic [63:0] e,
                                                longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic mau_res_t modular_result(mau_req_t r, logic [ModW-1:0] mod_reg);
    mau_res_t res;
    longint unsigned m, a, b, inv;
    bit ok;
    m = 64'(mod_reg);
    res.result = '0;
    res.no_inv = 1'b0;
    if (m < 2) return res;
    a = wrap_residue({{32{r.a[31]}}, r.a}, m);
    b = wrap_residue(r.b, m);
    case (r.mode)
      MODE_ADD: res.result = ModW'((a + b) % m);
      MODE_SUB: res.result = ModW'((a + m - b) % m);
      MODE_MUL: res.result = ModW'((a * b) % m);
      MODE_DIV: begin
        inv = mod_inverse(b, m, ok);
        if (ok) res.result = ModW'((a * inv) % m);
        else res.no_inv = 1'b1;
      end
      MODE_INV: begin
        inv = mod_inverse(a, m, ok);
        if (ok) res.result = ModW'(inv);
        else res.no_inv = 1'b1;
      end
      MODE_POW: begin
        if (r.b[63]) begin
          inv = mod_inverse(a, m, ok);
          if (ok) res.result = ModW'(mod_power(inv, 64'd0 - r.b, m));
          else res.no_inv = 1'b1;
        end else begin
          res.result = ModW'(mod_power(a, r.b, m));
        end
      end
      MODE_NEG: res.result = ModW'((m - a) % m);
      default: res.result = '0;
    endcase
    return res;
  endfunction

  // Cycle limit; the run is dead if it gets here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Track the modulus and predict each request at the edge it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      modulus_q <= ModReset;
      in_took <= 1'b0;
    end else begin
      if (cfg_we) modulus_q <= cfg_data;
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready)
        expected_results.push_back(modular_result(
          '{mode: mode_t'(in_mode), a: in_operand_a, b: in_operand_b}, modulus_q));
    end
  end

  // Driver: advance to the next pending request once the current one is taken.
  always @(negedge clk) begin
    mau_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_mode <= r.mode;
        in_operand_a <= r.a;
        in_operand_b <= r.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus a long hold whenever a token arrives.
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result against the oldest expectation.
  always @(posedge clk) begin
    mau_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %0d no_inverse %0d", $time, out_result,
                 out_no_inverse);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_result !== e.result) begin
          $display("%0t: result expected %0d actual %0d", $time, e.result, out_result);
          errors++;
        end
        if (out_no_inverse !== e.no_inv) begin
          $display("%0t: no_inverse expected %0d actual %0d", $time, e.no_inv,
                   out_no_inverse);
          errors++;
        end
      end
    end
  end

  task automatic push_req(mode_t mode, logic [31:0] a, logic [63:0] b);
    pending_reqs.push_back('{mode: mode, a: a, b: b});
  endtask

  // Wait for the queue and the block to run dry.
  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_modulus(logic [ModW-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_a();
    case ($urandom_range(3))
      0: return $urandom_range(20);
      1: return -$urandom_range(20);
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Keep most exponents short; a few span the full 64 bits.
  task automatic random_req();
    mode_t mode;
    logic [63:0] b;
    mode = mode_t'($urandom_range(7));
    if (mode == MODE_POW && $urandom_range(19) != 0) begin
      b = 64'($urandom_range(200));
      if ($urandom_range(2) == 0) b = -b;
    end else if ($urandom_range(3) == 0) begin
      b = $urandom_range(1) ? 64'd0 - 64'($urandom_range(20)) : 64'($urandom_range(20));
    end else begin
      b = {$urandom, $urandom};
    end
    push_req(mode, pick_a(), b);
  endtask

  initial begin
    logic [ModW-1:0] moduli[8];
    moduli = '{31'h7fff_ffff, 31'd2, 31'd0, 31'd1, 31'd65536, 31'd1000000007,
               31'd360, 31'h7fff_fffe};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 28;
    recv_idle_pct = 45;

    // Directed requests on the reset modulus of 13.
    push_req(MODE_ADD, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff);
    push_req(MODE_SUB, 32'h8000_0000, 64'h8000_0000_0000_0000);
    push_req(MODE_MUL, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    push_req(MODE_DIV, 32'd5, 64'd0);     // divisor with no inverse
    push_req(MODE_DIV, 32'd7, 64'd3);
    push_req(MODE_INV, 32'd0, 64'd0);     // zero has no inverse
    push_req(MODE_INV, 32'hffff_ffff, 64'd0);
    push_req(MODE_INV, 32'd26, 64'd0);    // multiple of the modulus
    push_req(MODE_POW, 32'd3, 64'd0);     // zero exponent
    push_req(MODE_POW, 32'd0, 64'd0);     // zero to the zero
    push_req(MODE_POW, 32'd2, 64'hffff_ffff_ffff_ffff);
    push_req(MODE_POW, 32'd0, -64'd3);    // negative power of zero
    push_req(MODE_POW, 32'd2, 64'h8000_0000_0000_0000); // most negative exponent
    push_req(MODE_POW, 32'hffff_fffb, 64'h7fff_ffff_ffff_ffff);
    push_req(MODE_NEG, 32'd0, 64'd0);
    push_req(MODE_NEG, 32'hffff_fff9, 64'd0);
    push_req(MODE_NONE, 32'd9, 64'd4);    // unused mode
    push_req(MODE_MUL, 32'h8000_0000, 64'h8000_0000_0000_0000);
    drain();

    foreach (moduli[p]) begin
      if (p == 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 28;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_modulus(moduli[p]);
      // Fill the block behind a long receive stall in one phase.
      if (p == 1) hold_token++;
      repeat (p == 2 || p == 3 ? 60 : 150) random_req();
      drain();
    end

    // Back to the reset value, then check the end state.
    write_modulus(ModReset);
    repeat (40) random_req();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
